// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Clocked on the rising edge, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- sv/eaqw_pkg.sv -----
// ----------------------------------------------------------------------------
// eaqw_pkg: shared types and constants
// Sequencer states, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package eaqw_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SQ_STEPS         = 20;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_HUM_REF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAS_W   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP    = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_S, ST_MUL_S, ST_AT_A, ST_MUL_A, ST_AT_B, ST_AT_C, ST_SQ_H,
    ST_MUL_P, ST_MUL_Q, ST_MUL_HD, ST_AT_D, ST_MUL_D, ST_MUL_W1, ST_MUL_W2,
    ST_SAT, ST_MUL_BK, ST_MUL_BG, ST_BASE, ST_MUL_HUM, ST_DIV_HUM,
    ST_MUL_GAS, ST_DIV_GAS, ST_SUM, ST_FIN
  } state_e;

  // round(atan(2^-i) * 65536)
  function automatic logic signed [19:0] atan_tab(input logic [4:0] i);
    logic signed [19:0] v;
    case (i)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30385;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/eaqw_in_if.sv -----
// ----------------------------------------------------------------------------
// eaqw_in_if: measurement channel
// One sensor measurement per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface eaqw_in_if;
  logic               valid;
  logic               ready;
  logic               measurement_ok;
  logic signed [15:0] temperature;
  logic [14:0]        humidity;
  logic               gas_ok;
  logic [23:0]        gas_resistance;

  modport source (output valid, measurement_ok, temperature, humidity, gas_ok,
                  gas_resistance, input ready);
  modport sink   (input valid, measurement_ok, temperature, humidity, gas_ok,
                  gas_resistance, output ready);
endinterface

// ----- sv/eaqw_out_if.sv -----
// ----------------------------------------------------------------------------
// eaqw_out_if: result channel
// One WBGT and air quality result per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface eaqw_out_if;
  logic               valid;
  logic               ready;
  logic               reading_valid;
  logic signed [15:0] wbgt;
  logic               air_quality_ok;
  logic [14:0]        air_quality;

  modport source (output valid, reading_valid, wbgt, air_quality_ok, air_quality,
                  input ready);
  modport sink   (input valid, reading_valid, wbgt, air_quality_ok, air_quality,
                  output ready);
endinterface

// ----- sv/env_air_quality_wbgt.sv -----
// ----------------------------------------------------------------------------
// env_air_quality_wbgt: indoor WBGT and air quality score
// Sequenced fixed-point datapath with one multiplier, a CORDIC stage,
// a bit-serial square root and a radix-2 divider.
// ----------------------------------------------------------------------------
// Each accepted word is one sensor measurement; each gives exactly one result
// word. A good measurement runs through one sequencer: two 20-step square
// roots, four CORDIC arctangents of CORDIC_STEPS steps each, two 16-step
// divisions when the gas reading is valid, and a chain of multiplies on one
// 33x24 multiplier. A failed measurement returns all-zero fields through the
// final state and the output register, and leaves the gas baseline untouched.
// The input is ready only in idle, but the result sits in an output register,
// so the next word is taken while the previous result still waits. Write the
// configuration only while idle.
// ----------------------------------------------------------------------------
module env_air_quality_wbgt #(
  parameter int CORDIC_STEPS = eaqw_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [eaqw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [eaqw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  eaqw_in_if.sink                          in_i,
  eaqw_out_if.source                       out_o
);

  localparam int SQ_N  = eaqw_pkg::SQ_STEPS;
  localparam int CNT_W = $clog2((CORDIC_STEPS > SQ_N) ? CORDIC_STEPS : SQ_N);

  eaqw_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // configuration
  logic [6:0]  hum_ref_q, gas_w_q;
  logic [10:0] keep_q;

  // captured measurement
  logic               ok_q, gv_q;
  logic signed [15:0] t_q;
  logic [14:0]        h_q;
  logic [23:0]        gr_q;

  // state kept across words
  logic [31:0] base_q;
  logic        seen_q;

  // datapath registers
  logic signed [56:0] prod_q, wacc_q;
  logic signed [27:0] x_q, y_q, tw_q;
  logic signed [19:0] z_q;
  logic [21:0]        srem_q;
  logic [19:0]        root_q;
  logic [31:0]        drem_q;
  logic [15:0]        quo_q, hum_q;
  logic signed [23:0] q_q;
  logic signed [15:0] wbgt_q;
  logic [14:0]        aq_q;

  // output register
  logic               ov_q, orv_q, oaqv_q;
  logic signed [15:0] owbgt_q;
  logic [14:0]        oaq_q;

  // clamped configuration
  logic [6:0]  r_c, w_c, hw;
  logic [10:0] k_c;
  always_comb begin
    r_c = (hum_ref_q == 7'd0) ? 7'd1 : ((hum_ref_q > 7'd99) ? 7'd99 : hum_ref_q);
    w_c = (gas_w_q > 7'd100) ? 7'd100 : gas_w_q;
    k_c = (keep_q > 11'd1024) ? 11'd1024 : keep_q;
    hw  = 7'd100 - w_c;
  end

  // Q16 views of the inputs
  logic signed [23:0] t16;
  logic [22:0]        h16;
  logic [31:0]        g32;
  assign t16 = {t_q, 8'h00};
  assign h16 = {h_q, 8'h00};
  assign g32 = {gr_q, 8'h00};

  logic hum_lo, hum_top, gas_div;
  assign hum_lo  = (h_q <= {r_c, 8'h00});
  assign hum_top = (h_q >= 15'd25600);
  assign gas_div = (base_q != 32'd0) && (g32 < base_q);

  // ---------------- shared multiplier ----------------
  logic               mul_en;
  logic signed [32:0] ma;
  logic signed [23:0] mb;
  logic signed [56:0] prod_d;
  logic signed [27:0] tw_fin;
  logic [14:0]        hum_n;

  assign tw_fin = tw_q + 28'(prod_q >>> 16) - 28'sd307104;
  assign hum_n  = hum_lo ? h_q : 15'(15'd25600 - h_q);

  always_comb begin
    mul_en = 1'b1;
    ma     = '0;
    mb     = '0;
    case (state_q)
      eaqw_pkg::ST_MUL_S:   begin ma = $signed({13'b0, root_q}); mb = 24'sd2549751; end
      eaqw_pkg::ST_MUL_A:   begin ma = 33'(t16); mb = 24'(z_q); end
      eaqw_pkg::ST_MUL_P:   begin ma = $signed({10'b0, h16}); mb = $signed({4'b0, root_q}); end
      eaqw_pkg::ST_MUL_Q:   begin ma = 33'(prod_q >>> 16); mb = 24'sd65740; end
      eaqw_pkg::ST_MUL_HD:  begin ma = $signed({10'b0, h16}); mb = 24'sd387570; end
      eaqw_pkg::ST_MUL_D:   begin ma = 33'(q_q); mb = 24'(z_q); end
      eaqw_pkg::ST_MUL_W1:  begin ma = 33'(tw_fin); mb = 24'sd45875; end
      eaqw_pkg::ST_MUL_W2:  begin ma = 33'(t16); mb = 24'sd19661; end
      eaqw_pkg::ST_MUL_BK:  begin ma = $signed({1'b0, base_q}); mb = $signed({13'b0, k_c}); end
      eaqw_pkg::ST_MUL_BG:  begin
        ma = $signed({1'b0, g32});
        mb = $signed({13'b0, 11'(11'd1024 - k_c)});
      end
      eaqw_pkg::ST_MUL_HUM: begin ma = $signed({18'b0, hum_n}); mb = $signed({17'b0, hw}); end
      eaqw_pkg::ST_MUL_GAS: begin ma = $signed({1'b0, g32}); mb = $signed({9'b0, w_c, 8'h00}); end
      default:              mul_en = 1'b0;
    endcase
  end
  assign prod_d = ma * mb;

  // ---------------- CORDIC step ----------------
  logic               at_first;
  logic signed [27:0] y_init, x_in, y_in, xs, ys, x_n, y_n;
  logic signed [19:0] z_in, z_n, ang;

  assign at_first = (cnt_q == '0);
  assign ang      = eaqw_pkg::atan_tab(5'(cnt_q));

  always_comb begin
    case (state_q)
      eaqw_pkg::ST_AT_B: y_init = 28'(t16) + $signed({5'b0, h16});
      eaqw_pkg::ST_AT_C: y_init = $signed({5'b0, h16}) - 28'sd109861;
      default:           y_init = 28'(prod_q >>> 24);
    endcase
    x_in = at_first ? 28'sd65536 : x_q;
    y_in = at_first ? y_init : y_q;
    z_in = at_first ? 20'sd0 : z_q;
    xs   = x_in >>> cnt_q;
    ys   = y_in >>> cnt_q;
    if (y_in < 0) begin
      x_n = x_in - ys;
      y_n = y_in + xs;
      z_n = z_in - ang;
    end else begin
      x_n = x_in + ys;
      y_n = y_in - xs;
      z_n = z_in + ang;
    end
  end

  // ---------------- square root step ----------------
  logic [39:0]      sq_v;
  logic [CNT_W-1:0] sq_idx;
  logic [1:0]       sq_pair;
  logic [21:0]      srem_in, srem_n;
  logic [19:0]      root_in, root_n;
  logic [23:0]      srem2, strial;

  always_comb begin
    if (state_q == eaqw_pkg::ST_SQ_S) begin
      sq_v = {24'(h16 + 23'd0) + 24'd544844, 16'h0000};
    end else begin
      sq_v = {1'b0, h16, 16'h0000};
    end
    sq_idx  = CNT_W'(SQ_N - 1) - cnt_q;
    sq_pair = 2'(sq_v >> {sq_idx, 1'b0});
    srem_in = at_first ? 22'd0 : srem_q;
    root_in = at_first ? 20'd0 : root_q;
    srem2   = {srem_in, sq_pair};
    strial  = {2'b00, root_in, 2'b01};
    if (srem2 >= strial) begin
      srem_n = 22'(srem2 - strial);
      root_n = {root_in[18:0], 1'b1};
    end else begin
      srem_n = srem2[21:0];
      root_n = {root_in[18:0], 1'b0};
    end
  end

  // ---------------- divider step ----------------
  logic [47:0] dv_n;
  logic [31:0] dv_d, drem_in, drem_n;
  logic [15:0] dv_lo;
  logic [32:0] drem2;
  logic        dge;

  always_comb begin
    dv_n    = prod_q[47:0];
    dv_lo   = dv_n[15:0];
    dv_d    = (state_q == eaqw_pkg::ST_DIV_GAS) ? base_q :
              (hum_lo ? {25'b0, r_c} : {25'b0, 7'(7'd100 - r_c)});
    drem_in = at_first ? dv_n[47:16] : drem_q;
    drem2   = {drem_in, dv_lo[4'(4'd15 - cnt_q[3:0])]};
    dge     = (drem2 >= {1'b0, dv_d});
    drem_n  = dge ? 32'(drem2 - {1'b0, dv_d}) : drem2[31:0];
  end

  // ---------------- saturation, baseline and score ----------------
  logic signed [57:0] wsum, wsh;
  logic signed [15:0] wbgt_n;
  logic [43:0]        bsum;
  logic [15:0]        hum_v, gas_v;
  logic [16:0]        sum_v;

  always_comb begin
    wsum = 58'(wacc_q) + 58'(prod_q) + 58'sd8388608;
    wsh  = wsum >>> 24;
    if (wsh > 58'sd32767) wbgt_n = 16'sh7fff;
    else if (wsh < -58'sd32768) wbgt_n = -16'sd32768;
    else wbgt_n = 16'(wsh);
    bsum  = 44'(wacc_q) + 44'(prod_q) + 44'd512;
    hum_v = (hum_top && !hum_lo) ? 16'd0 : hum_q;
    gas_v = gas_div ? quo_q : {1'b0, w_c, 8'h00};
    sum_v = {1'b0, hum_v} + {1'b0, gas_v};
  end

  // ---------------- sequencer ----------------
  logic last_at, last_sq, last_dv, out_load;
  assign last_at  = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
  assign last_sq  = (cnt_q == CNT_W'(SQ_N - 1));
  assign last_dv  = (cnt_q == CNT_W'(15));
  assign out_load = (state_q == eaqw_pkg::ST_FIN) && (!ov_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      eaqw_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = in_i.measurement_ok ? eaqw_pkg::ST_SQ_S : eaqw_pkg::ST_FIN;
        end
      end
      eaqw_pkg::ST_SQ_S: begin
        if (last_sq) state_d = eaqw_pkg::ST_MUL_S;
        else cnt_d = cnt_q + 1'b1;
      end
      eaqw_pkg::ST_MUL_S:  state_d = eaqw_pkg::ST_AT_A;
      eaqw_pkg::ST_AT_A: begin
        if (last_at) state_d = eaqw_pkg::ST_MUL_A;
        else cnt_d = cnt_q + 1'b1;
      end
      eaqw_pkg::ST_MUL_A:  state_d = eaqw_pkg::ST_AT_B;
      eaqw_pkg::ST_AT_B: begin
        if (last_at) state_d = eaqw_pkg::ST_AT_C;
        else cnt_d = cnt_q + 1'b1;
      end
      eaqw_pkg::ST_AT_C: begin
        if (last_at) state_d = eaqw_pkg::ST_SQ_H;
        else cnt_d = cnt_q + 1'b1;
      end
      eaqw_pkg::ST_SQ_H: begin
        if (last_sq) state_d = eaqw_pkg::ST_MUL_P;
        else cnt_d = cnt_q + 1'b1;
      end
      eaqw_pkg::ST_MUL_P:  state_d = eaqw_pkg::ST_MUL_Q;
      eaqw_pkg::ST_MUL_Q:  state_d = eaqw_pkg::ST_MUL_HD;
      eaqw_pkg::ST_MUL_HD: state_d = eaqw_pkg::ST_AT_D;
      eaqw_pkg::ST_AT_D: begin
        if (last_at) state_d = eaqw_pkg::ST_MUL_D;
        else cnt_d = cnt_q + 1'b1;
      end
      eaqw_pkg::ST_MUL_D:  state_d = eaqw_pkg::ST_MUL_W1;
      eaqw_pkg::ST_MUL_W1: state_d = eaqw_pkg::ST_MUL_W2;
      eaqw_pkg::ST_MUL_W2: state_d = eaqw_pkg::ST_SAT;
      eaqw_pkg::ST_SAT:    state_d = gv_q ? eaqw_pkg::ST_MUL_BK : eaqw_pkg::ST_FIN;
      eaqw_pkg::ST_MUL_BK: state_d = eaqw_pkg::ST_MUL_BG;
      eaqw_pkg::ST_MUL_BG: state_d = eaqw_pkg::ST_BASE;
      eaqw_pkg::ST_BASE:   state_d = eaqw_pkg::ST_MUL_HUM;
      eaqw_pkg::ST_MUL_HUM: state_d = eaqw_pkg::ST_DIV_HUM;
      eaqw_pkg::ST_DIV_HUM: begin
        if (last_dv) state_d = eaqw_pkg::ST_MUL_GAS;
        else cnt_d = cnt_q + 1'b1;
      end
      eaqw_pkg::ST_MUL_GAS: state_d = eaqw_pkg::ST_DIV_GAS;
      eaqw_pkg::ST_DIV_GAS: begin
        if (last_dv) state_d = eaqw_pkg::ST_SUM;
        else cnt_d = cnt_q + 1'b1;
      end
      eaqw_pkg::ST_SUM:    state_d = eaqw_pkg::ST_FIN;
      eaqw_pkg::ST_FIN: begin
        if (out_load) state_d = eaqw_pkg::ST_IDLE;
      end
      default:             state_d = eaqw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eaqw_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_i.ready = (state_q == eaqw_pkg::ST_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hum_ref_q <= 7'd40;
      gas_w_q   <= 7'd75;
      keep_q    <= 11'd1004;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        eaqw_pkg::CFG_HUM_REF: hum_ref_q <= cfg_data_i[6:0];
        eaqw_pkg::CFG_GAS_W:   gas_w_q   <= cfg_data_i[6:0];
        eaqw_pkg::CFG_KEEP:    keep_q    <= cfg_data_i;
        default:               ;
      endcase
    end
  end

  // baseline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      seen_q <= 1'b0;
    end else if (state_q == eaqw_pkg::ST_BASE) begin
      // replace on first or higher reading, else decay toward the reading
      base_q <= (!seen_q || g32 > base_q) ? g32 : bsum[41:10];
      seen_q <= 1'b1;
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ok_q <= in_i.measurement_ok;
      t_q  <= in_i.temperature;
      h_q  <= in_i.humidity;
      gv_q <= in_i.gas_ok;
      gr_q <= in_i.gas_resistance;
    end
    if (mul_en) prod_q <= prod_d;
    unique case (state_q)
      eaqw_pkg::ST_SQ_S, eaqw_pkg::ST_SQ_H: begin
        srem_q <= srem_n;
        root_q <= root_n;
        if (state_q == eaqw_pkg::ST_SQ_H && at_first) tw_q <= tw_q - 28'(z_q);
      end
      eaqw_pkg::ST_AT_A, eaqw_pkg::ST_AT_B, eaqw_pkg::ST_AT_C, eaqw_pkg::ST_AT_D: begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
        // fold the A term, then B, then subtract C as the next unit starts
        if (state_q == eaqw_pkg::ST_AT_B && at_first) tw_q <= 28'(prod_q >>> 16);
        if (state_q == eaqw_pkg::ST_AT_C && at_first) tw_q <= tw_q + 28'(z_q);
      end
      eaqw_pkg::ST_MUL_HD:  q_q <= 24'(prod_q >>> 24);
      eaqw_pkg::ST_MUL_W2, eaqw_pkg::ST_MUL_BG: wacc_q <= prod_q;
      eaqw_pkg::ST_SAT:     wbgt_q <= wbgt_n;
      eaqw_pkg::ST_DIV_HUM, eaqw_pkg::ST_DIV_GAS: begin
        drem_q <= drem_n;
        quo_q  <= {quo_q[14:0], dge};
      end
      eaqw_pkg::ST_MUL_GAS: hum_q <= quo_q;
      eaqw_pkg::ST_SUM:     aq_q <= (sum_v > 17'd25600) ? 15'd25600 : sum_v[14:0];
      default:              ;
    endcase
  end

  // output register: hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      orv_q   <= ok_q;
      owbgt_q <= ok_q ? wbgt_q : 16'sd0;
      oaqv_q  <= ok_q && gv_q;
      oaq_q   <= (ok_q && gv_q) ? aq_q : 15'd0;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.reading_valid  = orv_q;
  assign out_o.wbgt           = owbgt_q;
  assign out_o.air_quality_ok = oaqv_q;
  assign out_o.air_quality    = oaq_q;

endmodule

// ----- sv/eaqw_checker.sv -----
// ----------------------------------------------------------------------------
// eaqw_checker: port-level assertions
// Handshake and result sanity checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eaqw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_rv_i,
  input logic signed [15:0] out_wbgt_i,
  input logic               out_aqv_i,
  input logic [14:0]        out_aq_i
);

  logic out_stall;
  assign out_stall = out_valid_i && !out_ready_i;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_wbgt_i) && $stable(out_aq_i))
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `ASSERT_IMPLY(a_fail_zero, clk_i, rst_ni, out_valid_i && !out_rv_i,
                out_wbgt_i == 16'sd0 && !out_aqv_i && out_aq_i == 15'd0)
  `ASSERT_IMPLY(a_score_range, clk_i, rst_ni, out_valid_i, out_aq_i <= 15'd25600)

endmodule

bind env_air_quality_wbgt eaqw_checker u_eaqw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rv_i    (out_o.reading_valid),
  .out_wbgt_i  (out_o.wbgt),
  .out_aqv_i   (out_o.air_quality_ok),
  .out_aq_i    (out_o.air_quality)
);

// ----- dv/env_air_quality_wbgt_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// env_air_quality_wbgt_test: self-checking bench for the WBGT and air quality block
// Drives sensor measurements in bursts with random gaps, stalls the result
// channel on its own pattern, and checks every result word against an
// in-bench fixed-point predictor across several register settings.
// ----------------------------------------------------------------------------
module env_air_quality_wbgt_test;

  localparam int STEPS = eaqw_pkg::CORDIC_STEPS_DEF;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] temp;
    logic [14:0]        hum;
    logic               gv;
    logic [23:0]        gas;
  } meas_t;

  typedef struct packed {
    logic               rv;
    logic signed [15:0] wbgt;
    logic               aqv;
    logic [14:0]        aq;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                            cfg_we;
  logic [eaqw_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [eaqw_pkg::CFG_DATA_W-1:0] cfg_data;

  eaqw_in_if  in_if ();
  eaqw_out_if out_if ();

  env_air_quality_wbgt u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of registers and baseline state.
  logic [6:0]  hum_ref_q  = 7'd40;
  logic [6:0]  gas_wt_q   = 7'd75;
  logic [10:0] keep_q     = 11'd1004;
  logic [31:0] baseline_q = '0;
  logic        base_seen_q = 1'b0;

  meas_t    pending_meas[$];
  reading_t expected_readings[$];
  int       errors = 0;
  int       n_in = 0, n_out = 0;

  // round(atan(2^-i) * 65536)
  const longint ANGLE[24] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

  function automatic longint arctan_q16(longint a);
    longint x, y, z, xs, ys;
    x = 65536; y = a; z = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys; y = y + xs; z = z - ANGLE[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ANGLE[i];
      end
    end
    return z;
  endfunction

  function automatic longint root_q16(longint u);
    longint unsigned v, r, b;
    if (u <= 0) return 0;
    v = longint'(u) << 16;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic signed [15:0] heat_index(longint t16, longint h16);
    longint s, a, b, c, p, d, tw, w;
    s  = root_q16(h16 + 544844);
    a  = (t16 * arctan_q16((2549751 * s) >>> 24)) >>> 16;
    b  = arctan_q16(t16 + h16);
    c  = arctan_q16(h16 - 109861);
    p  = (h16 * root_q16(h16)) >>> 16;
    d  = (((p * 65740) >>> 24) * arctan_q16((387570 * h16) >>> 24)) >>> 16;
    tw = a + b - c + d - 307104;
    w  = (45875 * tw + 19661 * t16 + (64'sd1 <<< 23)) >>> 24;
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    return w[15:0];
  endfunction

  // Compute the expected word and advance the baseline.
  task automatic predict_reading(input meas_t m, output reading_t r);
    longint unsigned rr, ww, kk, hw, hum, gas, sum, g, hh;
    r = '0;
    if (!m.ok) return;
    r.rv   = 1'b1;
    r.wbgt = heat_index(longint'(m.temp) * 256, longint'({1'b0, m.hum}) * 256);
    if (!m.gv) return;
    rr = hum_ref_q; ww = gas_wt_q; kk = keep_q;
    if (rr < 1) rr = 1;
    if (rr > 99) rr = 99;
    if (ww > 100) ww = 100;
    if (kk > 1024) kk = 1024;
    hw = 100 - ww;
    g  = longint'(m.gas) << 8;
    hh = m.hum;
    if (!base_seen_q || g > baseline_q)
      baseline_q = g[31:0];
    else
      baseline_q = 32'((longint'(baseline_q) * kk + g * (1024 - kk) + 512) >> 10);
    base_seen_q = 1'b1;
    if (hh <= rr * 256) hum = hh * hw / rr;
    else if (hh >= 25600) hum = 0;
    else hum = (25600 - hh) * hw / (100 - rr);
    if (baseline_q > 0 && g < baseline_q) gas = g * ww * 256 / baseline_q;
    else gas = ww * 256;
    sum = hum + gas;
    if (sum > 25600) sum = 25600;
    r.aqv = 1'b1;
    r.aq  = sum[14:0];
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    errors++;
    $display("mismatch word %0d %s: got %0d, want %0d", n_out, field, got, want);
  endtask

  // ---------------------------------------------------------------- driver
  // Hold a word until accepted; advance in bursts separated by random gaps.
  int burst_left = 1, gap_left = 0;
  always @(posedge clk_i) begin
    reading_t r;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_reading(pending_meas[0], r);
        expected_readings.push_back(r);
        n_in++;
        pending_meas.pop_front();
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          in_if.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_meas.size() > 0) begin
          in_if.valid          <= 1'b1;
          in_if.measurement_ok <= pending_meas[0].ok;
          in_if.temperature    <= pending_meas[0].temp;
          in_if.humidity       <= pending_meas[0].hum;
          in_if.gas_ok         <= pending_meas[0].gv;
          in_if.gas_resistance <= pending_meas[0].gas;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            // Mostly short gaps; now and then one that spans a whole computation.
            gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 250)
                                                    : $urandom_range(0, 4);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  // Stall the result side on its own pattern, with quiet stretches.
  int stall_left = 0, cyc = 0;
  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (out_if.valid && out_if.ready) begin
        n_out++;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          e = expected_readings.pop_front();
          if (out_if.reading_valid !== e.rv)
            report_mismatch("reading_valid", out_if.reading_valid, e.rv);
          if (out_if.wbgt !== e.wbgt)
            report_mismatch("wbgt", out_if.wbgt, e.wbgt);
          if (out_if.air_quality_ok !== e.aqv)
            report_mismatch("air_quality_ok", out_if.air_quality_ok, e.aqv);
          if (out_if.air_quality !== e.aq)
            report_mismatch("air_quality", out_if.air_quality, e.aq);
        end
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_if.ready <= 1'b1;
        if ((cyc / 3000) % 3 != 0 && $urandom_range(0, 5) == 0)
          stall_left <= $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 3);
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic add_meas(input logic ok, input logic signed [15:0] t, input logic [14:0] h,
                          input logic gv, input logic [23:0] g);
    meas_t m;
    m.ok = ok; m.temp = t; m.hum = h; m.gv = gv; m.gas = g;
    pending_meas.push_back(m);
  endtask

  // Drain, let the sequencer settle, then write all three registers.
  task automatic set_registers(input logic [6:0] r, input logic [6:0] w, input logic [10:0] k);
    wait (pending_meas.size() == 0 && expected_readings.size() == 0);
    repeat (200) @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= eaqw_pkg::CFG_HUM_REF; cfg_data <= {4'd0, r};
    @(posedge clk_i);
    cfg_idx <= eaqw_pkg::CFG_GAS_W; cfg_data <= {4'd0, w};
    @(posedge clk_i);
    cfg_idx <= eaqw_pkg::CFG_KEEP; cfg_data <= k;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    hum_ref_q = r; gas_wt_q = w; keep_q = k;
  endtask

  task automatic random_meas(input int count);
    logic signed [15:0] t;
    logic [14:0] h;
    logic [23:0] g;
    int sel;
    repeat (count) begin
      sel = $urandom_range(0, 19);
      t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32000) - 10240);
      h = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 25600));
      g = 24'($urandom >> $urandom_range(8, 31));
      if ($urandom_range(0, 3) == 0 && base_seen_q)
        g = 24'((baseline_q >> 8) + $urandom_range(0, 64) - 32);
      add_meas(sel != 0 && sel != 1, t, h, sel != 2 && sel != 3, g);
    end
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.measurement_ok = 1'b0; in_if.temperature = '0;
    in_if.humidity = '0; in_if.gas_ok = 1'b0; in_if.gas_resistance = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0; cfg_idx = eaqw_pkg::CFG_HUM_REF; cfg_data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first baseline, higher and lower readings, failed and
    // gas-invalid measurements, range extremes and saturation.
    add_meas(1, 16'sd6400, 15'd12800, 1, 24'd50000);
    add_meas(1, 16'sd5000, 15'd10240, 1, 24'd80000);
    add_meas(1, 16'sd5000, 15'd10240, 1, 24'd20000);
    add_meas(0, 16'sd21760, 15'd25600, 1, 24'hFFFFFF);
    add_meas(1, 16'sd21760, 15'd25600, 0, 24'd1);
    add_meas(1, -16'sd10240, 15'd0, 1, 24'd0);
    add_meas(1, 16'sd32767, 15'h7FFF, 1, 24'hFFFFFF);
    add_meas(1, -16'sd32768, 15'h7FFF, 1, 24'd0);
    add_meas(1, 16'sd0, 15'd10241, 1, 24'd1);
    add_meas(1, 16'sd2560, 15'd25599, 1, 24'hFFFFFF);
    add_meas(0, -16'sd1, 15'h7FFF, 0, 24'hFFFFFF);
    add_meas(1, 16'sd7680, 15'd25601, 1, 24'h800000);
    add_meas(1, 16'sd1, 15'd1, 0, 24'h5A5A5A);
    add_meas(1, 16'sd12800, 15'd20480, 1, 24'hA5A5A5);
    random_meas(260);

    set_registers(7'd1, 7'd0, 11'd0);
    random_meas(270);
    set_registers(7'd99, 7'd100, 11'd1024);
    random_meas(270);
    set_registers(7'd0, 7'd127, 11'd2047);
    random_meas(270);
    set_registers(7'd127, 7'd50, 11'd512);
    random_meas(270);
    set_registers(7'($urandom_range(1, 99)), 7'($urandom_range(0, 100)),
                  11'($urandom_range(0, 1024)));
    random_meas(270);

    wait (pending_meas.size() == 0 && expected_readings.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d measurements, %0d result words over six register settings",
             n_in, n_out);
    if (errors == 0) begin
      $display("PASS env_air_quality_wbgt");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL env_air_quality_wbgt");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d words outstanding", expected_readings.size());
    $display("FAIL env_air_quality_wbgt");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/eaqw_pkg.sv
sv/eaqw_in_if.sv
sv/eaqw_out_if.sv
sv/env_air_quality_wbgt.sv
sv/eaqw_checker.sv
dv/env_air_quality_wbgt_test.sv
